// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the Exp-Golomb bit reader.
// Needs a clock named clk and a synchronous reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// expr must never be true.
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/exgb_pkg.sv =====
// Package of the Exp-Golomb bit reader: buffer size, derived widths and request codes.
// No dependencies; used by exp_golomb_bit_reader_top.
package exgb_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int VALUE_W      = 34;
  localparam int ACC_W        = 33;

  localparam logic [5:0] UE_ZERO_CAP = 6'd32;
  localparam logic [5:0] MAX_FIXED   = 6'd32;

  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_UE     = 3'd3;
  localparam logic [2:0] REQ_SE     = 3'd4;
  localparam logic [2:0] REQ_TE     = 3'd5;
  localparam logic [2:0] REQ_MORE   = 3'd6;

endpackage

// ===== rtl/exgb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; read data holds while no read is issued.
module exgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/exp_golomb_bit_reader_top.sv =====
// Top level of the Exp-Golomb bit reader: byte buffer, bit cursor and decode sequencer.
// Depends on exgb_pkg, exgb_ram and assert_macros.svh.
//
//   channel   direction  handshake              beat contents
//   request   in         start & !busy          req_type, data_byte, bit_count, te_max
//   result    out        done (one cycle)       value, at_end
//
// Clear, append and the unused request code are taken in the idle state and give no result.
// Reads and ue/se/te decodes walk the bitstream one bit per cycle, apart from byte fetches,
// through one shared bit extractor; the more-data query uses it too, then scans whole bytes.
// Each new byte under the cursor is loaded through S_FETCH: the miss is seen, then the RAM
// read is issued and the request resumes where it stopped.
// Reset is synchronous and needs no clearing pass over the RAM.
// The result beat cannot be stalled: done is high for exactly one cycle.
`include "assert_macros.svh"

module exp_golomb_bit_reader_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type,
  input  logic [7:0]         data_byte,
  input  logic [5:0]         bit_count,
  input  logic [7:0]         te_max,
  output logic               done,
  output logic signed [33:0] value,
  output logic               at_end
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT,
    S_PREFIX,
    S_MORE,
    S_SCAN,
    S_CHECK,
    S_FINISH
  } state_t;

  // How the accumulator is turned into the result value at the end.
  typedef enum logic [1:0] {
    FIN_RAW,
    FIN_UE,
    FIN_SE,
    FIN_TE1
  } fin_t;

  localparam logic [exgb_pkg::CNT_W-1:0] BUF_LIMIT =
    exgb_pkg::CNT_W'(exgb_pkg::BUFFER_BYTES);

  state_t state;
  state_t ret_state;
  fin_t   fin;

  logic [exgb_pkg::CNT_W-1:0] byte_count;
  logic [exgb_pkg::CNT_W-1:0] read_position;
  logic [exgb_pkg::CNT_W-1:0] scan_addr;
  logic [2:0]                 bit_idx;
  logic                       cache_ok;
  logic [5:0]                 cnt;
  logic [exgb_pkg::ACC_W-1:0] acc;

  logic                         ram_wr_en;
  logic                         ram_rd_en;
  logic [exgb_pkg::ADDR_W-1:0]  ram_rd_addr;
  logic [7:0]                   ram_rd_data;

  logic                         past;
  logic                         need_fetch;
  logic                         cur_bit;
  logic [exgb_pkg::CNT_W-1:0]   pos_after;
  logic                         past_after;
  logic [7:0]                   low_mask;
  logic [5:0]                   fixed_n;
  logic [exgb_pkg::VALUE_W-1:0] result;
  logic [exgb_pkg::VALUE_W-1:0] half_code;

  // The RAM read register doubles as the cache of the byte under the cursor;
  // cache_ok says whether it still holds that byte.
  exgb_ram #(
    .WIDTH (8),
    .DEPTH (exgb_pkg::BUFFER_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (byte_count[exgb_pkg::ADDR_W-1:0]),
    .wr_data (data_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign busy      = (state != S_IDLE);
  assign ram_wr_en = start && !busy && (req_type == exgb_pkg::REQ_APPEND) &&
                     (byte_count < BUF_LIMIT);
  assign ram_rd_en = (state == S_FETCH) || ((state == S_SCAN) && (scan_addr < byte_count));
  assign ram_rd_addr = (state == S_SCAN) ? scan_addr[exgb_pkg::ADDR_W-1:0]
                                         : read_position[exgb_pkg::ADDR_W-1:0];

  // Shared bit extractor: the bit under the cursor and where the cursor goes next.
  // Bits beyond the appended data read as zero and need no fetch.
  always_comb begin
    past       = (read_position >= byte_count);
    need_fetch = !past && !cache_ok;
    cur_bit    = past ? 1'b0 : ram_rd_data[bit_idx];
    pos_after  = read_position;
    if ((bit_idx == 3'd0) && (read_position < BUF_LIMIT)) begin
      pos_after = read_position + 1'b1;
    end
    past_after = (pos_after >= byte_count);
    low_mask   = (8'd1 << bit_idx) - 8'd1;
    fixed_n    = (bit_count > exgb_pkg::MAX_FIXED) ? exgb_pkg::MAX_FIXED : bit_count;
  end

  // The ue accumulator holds code_num + 1 (leading one then suffix bits), so the
  // code is acc - 1 and the se magnitude is acc >> 1 with the sign from acc[0].
  always_comb begin
    half_code = {2'b00, acc[exgb_pkg::ACC_W-1:1]};
    case (fin)
      FIN_RAW: result = {1'b0, acc};
      FIN_UE:  result = {1'b0, acc - 1'b1};
      FIN_SE:  result = acc[0] ? (~half_code + 1'b1) : half_code;
      FIN_TE1: result = {{(exgb_pkg::VALUE_W-1){1'b0}}, ~acc[0]};
      default: result = {1'b0, acc};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret_state     <= S_IDLE;
      byte_count    <= '0;
      read_position <= '0;
      bit_idx       <= 3'd7;
      cache_ok      <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (req_type)
              exgb_pkg::REQ_CLEAR: begin
                byte_count    <= '0;
                read_position <= '0;
                bit_idx       <= 3'd7;
                cache_ok      <= 1'b0;
              end
              exgb_pkg::REQ_APPEND: begin
                if (byte_count < BUF_LIMIT) begin
                  byte_count <= byte_count + 1'b1;
                end
              end
              exgb_pkg::REQ_READ: begin
                acc   <= '0;
                cnt   <= fixed_n;
                fin   <= FIN_RAW;
                state <= (fixed_n == 6'd0) ? S_FINISH : S_SHIFT;
              end
              exgb_pkg::REQ_UE: begin
                acc   <= exgb_pkg::ACC_W'(1);
                cnt   <= '0;
                fin   <= FIN_UE;
                state <= S_PREFIX;
              end
              exgb_pkg::REQ_SE: begin
                acc   <= exgb_pkg::ACC_W'(1);
                cnt   <= '0;
                fin   <= FIN_SE;
                state <= S_PREFIX;
              end
              exgb_pkg::REQ_TE: begin
                if (te_max == 8'd1) begin
                  acc   <= '0;
                  cnt   <= 6'd1;
                  fin   <= FIN_TE1;
                  state <= S_SHIFT;
                end else if (te_max > 8'd1) begin
                  acc   <= exgb_pkg::ACC_W'(1);
                  cnt   <= '0;
                  fin   <= FIN_UE;
                  state <= S_PREFIX;
                end else begin
                  acc   <= '0;
                  fin   <= FIN_RAW;
                  state <= S_FINISH;
                end
              end
              exgb_pkg::REQ_MORE: begin
                fin   <= FIN_RAW;
                state <= S_MORE;
              end
              default: begin
              end
            endcase
          end
        end
        S_FETCH: begin
          cache_ok <= 1'b1;
          state    <= ret_state;
        end
        S_SHIFT: begin
          if (need_fetch) begin
            ret_state <= S_SHIFT;
            state     <= S_FETCH;
          end else begin
            read_position <= pos_after;
            bit_idx       <= bit_idx - 1'b1;
            if (bit_idx == 3'd0) begin
              cache_ok <= 1'b0;
            end
            acc <= {acc[exgb_pkg::ACC_W-2:0], cur_bit};
            cnt <= cnt - 1'b1;
            if (cnt == 6'd1) begin
              state <= S_FINISH;
            end
          end
        end
        S_PREFIX: begin
          if (need_fetch) begin
            ret_state <= S_PREFIX;
            state     <= S_FETCH;
          end else begin
            read_position <= pos_after;
            bit_idx       <= bit_idx - 1'b1;
            if (bit_idx == 3'd0) begin
              cache_ok <= 1'b0;
            end
            if (cur_bit || (cnt == exgb_pkg::UE_ZERO_CAP) || past_after) begin
              state <= (cnt == 6'd0) ? S_FINISH : S_SHIFT;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_MORE: begin
          if (past) begin
            acc   <= '0;
            state <= S_FINISH;
          end else if (need_fetch) begin
            ret_state <= S_MORE;
            state     <= S_FETCH;
          end else if (!ram_rd_data[bit_idx] || ((ram_rd_data & low_mask) != 8'd0)) begin
            acc   <= exgb_pkg::ACC_W'(1);
            state <= S_FINISH;
          end else begin
            // The scan reuses the read register, so the cached byte is lost.
            scan_addr <= read_position + 1'b1;
            cache_ok  <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_addr >= byte_count) begin
            acc   <= '0;
            state <= S_FINISH;
          end else begin
            scan_addr <= scan_addr + 1'b1;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ram_rd_data != 8'd0) begin
            acc   <= exgb_pkg::ACC_W'(1);
            state <= S_FINISH;
          end else begin
            state <= S_SCAN;
          end
        end
        S_FINISH: begin
          done   <= 1'b1;
          value  <= $signed(result);
          at_end <= past;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result beat only ever follows a request that kept the block busy.
  `ASSERT_IMPLIES(a_done_after_busy, done, $past(busy) && !busy)
  // The cursor saturates at the buffer size and never runs beyond it.
  `ASSERT_NEVER(a_pos_saturates, read_position > BUF_LIMIT)
  // The fill count never exceeds the buffer size.
  `ASSERT_NEVER(a_count_bounded, byte_count > BUF_LIMIT)
  // Clear and append, which give no result, finish in the cycle they are taken.
  `ASSERT_NEXT(a_short_requests, start && !busy && ((req_type == exgb_pkg::REQ_CLEAR) ||
    (req_type == exgb_pkg::REQ_APPEND)), !busy && !done)

endmodule

// ===== tb/sv/tb_exp_golomb_bit_reader_top.sv =====
// Self-checking testbench for exp_golomb_bit_reader_top: directed table and random
// streams, checked against a bit-exact predictor of the bit reader or, for pinned rows, typed values.
// Depends on exgb_pkg and the RTL of exp_golomb_bit_reader_top.
module tb_exp_golomb_bit_reader_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names every request code but the spare one, which the block ignores.
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [33:0] value;
    logic        at_end;
  } reader_result_t;

  // One row of the directed table. When pinned is set the expected beat is the typed
  // one; otherwise the predictor supplies it.
  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  data;
    logic [5:0]  count;
    logic [7:0]  tmax;
    logic        pinned;
    logic [33:0] value;
    logic        at_end;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // Straight out of reset the buffer is empty, so every bit reads as zero.
    '{exgb_pkg::REQ_READ,   8'h00, 6'd8,  8'h00, 1'b1, 34'd0, 1'b1},
    '{exgb_pkg::REQ_MORE,   8'h00, 6'd0,  8'h00, 1'b1, 34'd0, 1'b1},
    '{exgb_pkg::REQ_UE,     8'h00, 6'd0,  8'h00, 1'b1, 34'd0, 1'b1},
    '{exgb_pkg::REQ_CLEAR,  8'h00, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{REQ_UNUSED,           8'hFF, 6'd63, 8'hFF, 1'b0, 34'd0, 1'b0},
    // 32 zeros, a one, then 32 ones: the largest ue code number, 2^33 - 2.
    '{exgb_pkg::REQ_APPEND, 8'h00, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_APPEND, 8'h00, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_APPEND, 8'h00, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_APPEND, 8'h00, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_APPEND, 8'hFF, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_APPEND, 8'hFF, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_APPEND, 8'hFF, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_APPEND, 8'hFF, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_APPEND, 8'h81, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_UE,     8'h00, 6'd0,  8'h00, 1'b1, 34'h1_FFFF_FFFE, 1'b0},
    // Seven bits are left (0000001): the more-data query sees a zero next, and the se
    // code that follows runs into the end of the buffer.
    '{exgb_pkg::REQ_MORE,   8'h00, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_SE,     8'h00, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_TE,     8'h00, 6'd0,  8'h00, 1'b1, 34'd0, 1'b1},
    '{exgb_pkg::REQ_CLEAR,  8'h00, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    // One byte exercised through both nonzero te ranges, more-data queries and a trailing fixed read.
    '{exgb_pkg::REQ_APPEND, 8'h5A, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_TE,     8'h00, 6'd0,  8'h01, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_TE,     8'h00, 6'd0,  8'hFF, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_MORE,   8'h00, 6'd0,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_READ,   8'h00, 6'd6,  8'h00, 1'b0, 34'd0, 1'b0},
    '{exgb_pkg::REQ_MORE,   8'h00, 6'd0,  8'h00, 1'b1, 34'd0, 1'b1}
  };

  // Sender idle rate for each random phase, in percent.
  int idle_plan [3] = '{11, 83, 0};

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         req_type;
  logic [7:0]         data_byte;
  logic [5:0]         bit_count;
  logic [7:0]         te_max;
  logic               done;
  logic signed [33:0] value;
  logic               at_end;

  // Shadow copy of the reader state that the predictor works on.
  logic [7:0]  shadow_bytes [exgb_pkg::BUFFER_BYTES];
  int unsigned shadow_count;
  int unsigned shadow_pos;
  int unsigned shadow_left;

  reader_result_t pending_results [$];
  int             fail_count;
  int             beat_total;
  int             sender_idle_pct;

  exp_golomb_bit_reader_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .data_byte (data_byte),
    .bit_count (bit_count),
    .te_max    (te_max),
    .done      (done),
    .value     (value),
    .at_end    (at_end)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor of the bit reader.
  // ---------------------------------------------------------------------------

  // Takes the next bit, MSB first. Bits at or past the end read as zero, and the
  // byte cursor stops advancing once it reaches the size of the store.
  function automatic logic pull_bit();
    logic b;
    b = 1'b0;
    shadow_left = (shadow_left - 1) & 7;
    if (shadow_pos < shadow_count && shadow_pos < exgb_pkg::BUFFER_BYTES)
      b = shadow_bytes[shadow_pos][shadow_left];
    if (shadow_left == 0) begin
      if (shadow_pos < exgb_pkg::BUFFER_BYTES)
        shadow_pos++;
      shadow_left = 8;
    end
    return b;
  endfunction

  function automatic logic [63:0] pull_bits(input int unsigned n);
    logic [63:0] r;
    r = '0;
    for (int unsigned k = 0; k < n; k++)
      r = {r[62:0], pull_bit()};
    return r;
  endfunction

  // Unsigned Exp-Golomb. The zero count stops at the cap (the bit after the cap is
  // still consumed), and a zero that lands the cursor on the end stops it uncounted.
  function automatic logic [63:0] decode_exp_golomb();
    int unsigned zeros;
    logic        stop;
    logic        b;
    zeros = 0;
    stop  = 1'b0;
    while (!stop) begin
      b = pull_bit();
      if (b || zeros >= exgb_pkg::UE_ZERO_CAP || shadow_pos >= shadow_count)
        stop = 1'b1;
      else
        zeros++;
    end
    return pull_bits(zeros) + ((64'd1 << zeros) - 64'd1);
  endfunction

  // More RBSP data: true unless the cursor is at the end or the next bit is the last one set in the buffer.
  function automatic logic rbsp_more_data();
    logic [7:0]  cur;
    int unsigned below;
    logic        found;
    if (shadow_pos >= shadow_count || shadow_pos >= exgb_pkg::BUFFER_BYTES)
      return 1'b0;
    cur   = shadow_bytes[shadow_pos];
    below = shadow_left - 1;
    if (!cur[below])
      return 1'b1;
    if ((cur & ((8'd1 << below) - 8'd1)) != 8'd0)
      return 1'b1;
    found = 1'b0;
    for (int unsigned k = shadow_pos + 1;
         k < shadow_count && k < exgb_pkg::BUFFER_BYTES; k++)
      if (shadow_bytes[k] != 8'd0)
        found = 1'b1;
    return found;
  endfunction

  function automatic void clear_shadow();
    shadow_count = 0;
    shadow_pos   = 0;
    shadow_left  = 8;
  endfunction

  // Applies one request to the shadow state and returns the result beat, if any.
  function automatic void predict_request(input logic [2:0] req, input logic [7:0] data,
                                          input logic [5:0] count, input logic [7:0] tmax,
                                          output logic yields, output reader_result_t res);
    logic [63:0] v;
    logic [63:0] code;
    v      = '0;
    yields = 1'b1;
    case (req)
      exgb_pkg::REQ_CLEAR: begin
        clear_shadow();
        yields = 1'b0;
      end
      exgb_pkg::REQ_APPEND: begin
        if (shadow_count < exgb_pkg::BUFFER_BYTES) begin
          shadow_bytes[shadow_count] = data;
          shadow_count++;
        end
        yields = 1'b0;
      end
      exgb_pkg::REQ_READ: begin
        v = pull_bits((count > exgb_pkg::MAX_FIXED) ? exgb_pkg::MAX_FIXED : count);
      end
      exgb_pkg::REQ_UE: begin
        v = decode_exp_golomb();
      end
      exgb_pkg::REQ_SE: begin
        code = decode_exp_golomb();
        v    = code[0] ? (code + 64'd1) >> 1 : 64'd0 - (code >> 1);
      end
      exgb_pkg::REQ_TE: begin
        if (tmax == 8'd1)
          v = {63'd0, ~pull_bit()};
        else if (tmax > 8'd1)
          v = decode_exp_golomb();
      end
      exgb_pkg::REQ_MORE: begin
        v = {63'd0, rbsp_more_data()};
      end
      default: begin
        yields = 1'b0;
      end
    endcase
    res.value  = v[33:0];
    res.at_end = (shadow_pos >= shadow_count);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Puts one request beat on the ports, possibly after an idle gap, and returns at the
  // edge that accepts it. Start is only lowered at the head of a gap, so a back-to-back
  // beat never sees start lowered and raised within one time step.
  task automatic send_beat(input logic [2:0] req, input logic [7:0] data,
                           input logic [5:0] count, input logic [7:0] tmax);
    logic           yields;
    reader_result_t res;
    if ($urandom_range(99, 0) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < sender_idle_pct);
    end
    start     <= 1'b1;
    req_type  <= req;
    data_byte <= data;
    bit_count <= count;
    te_max    <= tmax;
    do @(posedge clk); while (busy);
    predict_request(req, data, count, tmax, yields, res);
    if (yields)
      pending_results.push_back(res);
    if (req != REQ_UNUSED)
      beat_total++;
  endtask

  // Holds the sender off until every expected result beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Byte content biased toward zeros and single set bits, so that long ue prefixes,
  // trailing-bit patterns and the more-data scan all come up often.
  function automatic logic [7:0] stream_byte();
    case ($urandom_range(9, 0))
      0, 1, 2: return 8'h00;
      3:       return 8'h80;
      4:       return 8'h01;
      5:       return 8'd1 << $urandom_range(7, 0);
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // One random stretch of bitstream: mostly a clear, a run of appends and a run of
  // decodes with random content; sometimes no clear, appends mixed into the reads,
  // spare request codes, and reads that run well past the end.
  task automatic send_random_stream();
    int unsigned len;
    int unsigned reads;
    int unsigned pick;
    logic [5:0]  count;
    logic [7:0]  tmax;
    if ($urandom_range(9, 0) != 0)
      send_beat(exgb_pkg::REQ_CLEAR, 8'($urandom), 6'($urandom), 8'($urandom));
    len = ($urandom_range(19, 0) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 0);
    for (int unsigned k = 0; k < len; k++)
      send_beat(exgb_pkg::REQ_APPEND, stream_byte(), 6'($urandom), 8'($urandom));
    reads = $urandom_range(14, 1);
    for (int unsigned k = 0; k < reads; k++) begin
      pick  = $urandom_range(99, 0);
      count = ($urandom_range(9, 0) == 0) ? 6'($urandom_range(63, 33))
                                          : 6'($urandom_range(32, 0));
      case ($urandom_range(3, 0))
        0:       tmax = 8'd0;
        1:       tmax = 8'd1;
        default: tmax = 8'($urandom_range(255, 0));
      endcase
      if (pick < 20)
        send_beat(exgb_pkg::REQ_READ, 8'($urandom), count, 8'($urandom));
      else if (pick < 40)
        send_beat(exgb_pkg::REQ_UE, 8'($urandom), count, tmax);
      else if (pick < 55)
        send_beat(exgb_pkg::REQ_SE, 8'($urandom), count, tmax);
      else if (pick < 70)
        send_beat(exgb_pkg::REQ_TE, 8'($urandom), count, tmax);
      else if (pick < 88)
        send_beat(exgb_pkg::REQ_MORE, 8'($urandom), count, tmax);
      else if (pick < 94)
        send_beat(exgb_pkg::REQ_APPEND, stream_byte(), count, tmax);
      else
        send_beat(REQ_UNUSED, 8'($urandom), count, tmax);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: every done beat is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reader_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: value %0d at_end %0b", value, at_end);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), value);
          fail_count++;
        end
        if (at_end !== want.at_end) begin
          $error("at_end: expected %0b, got %0b", want.at_end, at_end);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mark;
    clk             = 1'b0;
    rst             = 1'b1;
    start           = 1'b0;
    req_type        = exgb_pkg::REQ_CLEAR;
    data_byte       = 8'h00;
    bit_count       = 6'd0;
    te_max          = 8'h00;
    fail_count      = 0;
    beat_total      = 0;
    sender_idle_pct = 0;
    clear_shadow();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. A pinned row overwrites the prediction it just queued with the
    // value typed in the table.
    sender_idle_pct = idle_plan[0];
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_beat(directed_rows[r].req, directed_rows[r].data, directed_rows[r].count,
                directed_rows[r].tmax);
      if (directed_rows[r].pinned)
        pending_results[pending_results.size() - 1] =
          '{value: directed_rows[r].value, at_end: directed_rows[r].at_end};
    end
    drain_results();

    // Random streams: a light sender gap rate, then a heavy one, then none.
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_plan[ph];
      mark = beat_total;
      while (beat_total - mark < 400)
        send_random_stream();
      drain_results();
    end

    // Quiet cycles to catch any stray result beat.
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including every sender gap.
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
